### rtl/touch_sample_filter_calibrate_assert.svh
// Assertion macros shared by the checker files of the touch filter.
// Needs a clk and an active-low rst_n in the including scope.
`ifndef TOUCH_SAMPLE_FILTER_CALIBRATE_ASSERT_SVH
`define TOUCH_SAMPLE_FILTER_CALIBRATE_ASSERT_SVH

// Same-cycle implication, masked while reset is asserted.
`define TSFC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define TSFC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/tsfc_pkg.sv
// Shared constants, codes and stage records for the touch sample filter.
// No dependencies; every module file references it by scoped names.
package tsfc_pkg;

  localparam int SAMPLES_PER_GROUP = 5;

  localparam int SMP_W     = 13;
  localparam int SUM_W     = $clog2(SAMPLES_PER_GROUP * ((1 << SMP_W) - 1) + 1);
  localparam int CNT_W     = $clog2(SAMPLES_PER_GROUP);
  localparam int TRIM_DIV  = SAMPLES_PER_GROUP - 2;

  // exact reciprocal for the trimmed-sum divide: floor(x*M / 2^K) == x / TRIM_DIV
  localparam int DIV_K      = SUM_W + $clog2(TRIM_DIV);
  localparam int DIV_M_W    = DIV_K + 1;
  localparam longint unsigned DIV_M = ((64'd1 << DIV_K) + TRIM_DIV - 1) / TRIM_DIV;
  localparam int DIV_PROD_W = SUM_W + DIV_M_W;

  localparam int CFG_W      = 52;
  localparam int CFG_IDX_W  = 3;
  localparam int GAIN_W     = 24;
  localparam int OFS_W      = 16;
  localparam int SCR_W      = 12;
  localparam int FRAC_W     = 16;
  localparam int CAL_PROD_W = GAIN_W + SMP_W + 1;
  localparam int CAL_V_W    = CAL_PROD_W + 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_JITTER    = 3'd0,
    REG_RAW_WINDOW    = 3'd1,
    REG_X_GAIN        = 3'd2,
    REG_Y_GAIN        = 3'd3,
    REG_X_OFFSET      = 3'd4,
    REG_Y_OFFSET      = 3'd5,
    REG_SCREEN_WIDTH  = 3'd6,
    REG_SCREEN_HEIGHT = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    GRP_X1 = 2'd0,
    GRP_Y1 = 2'd1,
    GRP_X2 = 2'd2,
    GRP_Y2 = 2'd3
  } grp_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_UNSTABLE = 2'd1,
    STAT_RANGE    = 2'd2
  } status_t;

  // finished group: trimmed sum and which group it was
  typedef struct packed {
    logic [SUM_W-1:0] trim;
    grp_t             grp;
  } trim_t;

  // both axes of one sequence, after the stability check
  typedef struct packed {
    logic             unstable;
    logic [SMP_W-1:0] dx;
    logic [SMP_W-1:0] dy;
    logic [SMP_W-1:0] ax;
    logic [SMP_W-1:0] ay;
  } pair_t;

endpackage

### rtl/tsfc_accum.sv
// Input register and per-group running sum / min / max.
// Depends on tsfc_pkg. Emits one trimmed sum per finished group.
module tsfc_accum (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_start_req,
  input  logic [15:0]                 in_raw_word,
  output logic                        trim_vld,
  input  logic                        trim_rdy,
  output tsfc_pkg::trim_t             trim
);

  logic                          a_vld_r, a_vld_nxt;
  logic                          a_start_r, a_start_nxt;
  logic [tsfc_pkg::SMP_W-1:0]    a_smp_r, a_smp_nxt;

  logic                          b_vld_r, b_vld_nxt;
  tsfc_pkg::trim_t               b_trim_r, b_trim_nxt;

  logic [tsfc_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  tsfc_pkg::grp_t                grp_r, grp_nxt;
  logic [tsfc_pkg::SUM_W-1:0]    sum_r, sum_nxt;
  logic [tsfc_pkg::SMP_W-1:0]    min_r, min_nxt;
  logic [tsfc_pkg::SMP_W-1:0]    max_r, max_nxt;

  logic                          a_rdy, b_rdy;
  logic [tsfc_pkg::CNT_W-1:0]    cnt_base;
  tsfc_pkg::grp_t                grp_base;
  logic [tsfc_pkg::SUM_W-1:0]    sum_base, sum_add, trim_val;
  logic [tsfc_pkg::SMP_W-1:0]    min_base, max_base, min_new, max_new;
  logic                          last;

  assign b_rdy    = !b_vld_r || trim_rdy;
  assign a_rdy    = !a_vld_r || b_rdy;
  assign in_stall = !a_rdy;
  assign trim_vld = b_vld_r;
  assign trim     = b_trim_r;

  // restart drops the partial sequence; this sample opens the new one
  always_comb begin
    if (a_start_r) begin
      cnt_base = '0;
      grp_base = tsfc_pkg::GRP_X1;
      sum_base = '0;
      min_base = '1;
      max_base = '0;
    end else begin
      cnt_base = cnt_r;
      grp_base = grp_r;
      sum_base = sum_r;
      min_base = min_r;
      max_base = max_r;
    end
    sum_add  = sum_base + tsfc_pkg::SUM_W'(a_smp_r);
    min_new  = (a_smp_r < min_base) ? a_smp_r : min_base;
    max_new  = (a_smp_r > max_base) ? a_smp_r : max_base;
    last     = (cnt_base == tsfc_pkg::CNT_W'(tsfc_pkg::SAMPLES_PER_GROUP - 1));
    trim_val = sum_add - tsfc_pkg::SUM_W'(max_new) - tsfc_pkg::SUM_W'(min_new);
  end

  always_comb begin
    a_vld_nxt   = a_vld_r;
    a_start_nxt = a_start_r;
    a_smp_nxt   = a_smp_r;
    b_vld_nxt   = b_vld_r;
    b_trim_nxt  = b_trim_r;
    cnt_nxt     = cnt_r;
    grp_nxt     = grp_r;
    sum_nxt     = sum_r;
    min_nxt     = min_r;
    max_nxt     = max_r;

    if (a_rdy) begin
      a_vld_nxt = in_valid;
      if (in_valid) begin
        a_start_nxt = in_start_req;
        a_smp_nxt   = in_raw_word[15:3];
      end
    end

    if (b_rdy) begin
      b_vld_nxt = a_vld_r && last;
      if (a_vld_r) begin
        b_trim_nxt.trim = trim_val;
        b_trim_nxt.grp  = grp_base;
        if (last) begin
          cnt_nxt = '0;
          grp_nxt = tsfc_pkg::grp_t'(grp_base + 2'd1);
          sum_nxt = '0;
          min_nxt = '1;
          max_nxt = '0;
        end else begin
          cnt_nxt = cnt_base + tsfc_pkg::CNT_W'(1);
          grp_nxt = grp_base;
          sum_nxt = sum_add;
          min_nxt = min_new;
          max_nxt = max_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      cnt_r   <= '0;
      grp_r   <= tsfc_pkg::GRP_X1;
      sum_r   <= '0;
      min_r   <= '1;
      max_r   <= '0;
    end else begin
      a_vld_r <= a_vld_nxt;
      b_vld_r <= b_vld_nxt;
      cnt_r   <= cnt_nxt;
      grp_r   <= grp_nxt;
      sum_r   <= sum_nxt;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_start_r <= a_start_nxt;
    a_smp_r   <= a_smp_nxt;
    b_trim_r  <= b_trim_nxt;
  end

endmodule

### rtl/tsfc_mean.sv
// Trimmed-mean divide, storage of the first three means, stability check.
// Depends on tsfc_pkg. One pair record per complete sequence.
module tsfc_mean (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        trim_vld,
  output logic                        trim_rdy,
  input  tsfc_pkg::trim_t             trim,
  input  logic [tsfc_pkg::SMP_W-1:0]  max_jitter,
  output logic                        pair_vld,
  input  logic                        pair_rdy,
  output tsfc_pkg::pair_t             pair
);

  logic                              c_vld_r, c_vld_nxt;
  logic [tsfc_pkg::SMP_W-1:0]        c_mean_r, c_mean_nxt;
  tsfc_pkg::grp_t                    c_grp_r, c_grp_nxt;

  logic [tsfc_pkg::SMP_W-1:0]        fx_r, fx_nxt;
  logic [tsfc_pkg::SMP_W-1:0]        fy_r, fy_nxt;
  logic [tsfc_pkg::SMP_W-1:0]        sx_r, sx_nxt;

  logic                              d_vld_r, d_vld_nxt;
  tsfc_pkg::pair_t                   d_pair_r, d_pair_nxt;

  logic                              c_rdy, d_rdy;
  logic [tsfc_pkg::DIV_PROD_W-1:0]   prod;
  logic [tsfc_pkg::SMP_W-1:0]        dx, dy;
  logic [tsfc_pkg::SMP_W:0]          sum_x, sum_y;

  assign d_rdy    = !d_vld_r || pair_rdy;
  assign c_rdy    = !c_vld_r || d_rdy;
  assign trim_rdy = c_rdy;
  assign pair_vld = d_vld_r;
  assign pair     = d_pair_r;

  // divide by the group size less two through a constant reciprocal
  assign prod = tsfc_pkg::DIV_PROD_W'(trim.trim) *
                tsfc_pkg::DIV_PROD_W'(tsfc_pkg::DIV_M);

  // x1 = fx, x2 = sx, y1 = fy, y2 = the mean now in stage C
  always_comb begin
    dx    = (fx_r > sx_r) ? (fx_r - sx_r) : (sx_r - fx_r);
    dy    = (fy_r > c_mean_r) ? (fy_r - c_mean_r) : (c_mean_r - fy_r);
    sum_x = {1'b0, fx_r} + {1'b0, sx_r};
    sum_y = {1'b0, fy_r} + {1'b0, c_mean_r};
  end

  always_comb begin
    c_vld_nxt  = c_vld_r;
    c_mean_nxt = c_mean_r;
    c_grp_nxt  = c_grp_r;
    fx_nxt     = fx_r;
    fy_nxt     = fy_r;
    sx_nxt     = sx_r;
    d_vld_nxt  = d_vld_r;
    d_pair_nxt = d_pair_r;

    if (c_rdy) begin
      c_vld_nxt = trim_vld;
      if (trim_vld) begin
        c_mean_nxt = prod[tsfc_pkg::DIV_K +: tsfc_pkg::SMP_W];
        c_grp_nxt  = trim.grp;
      end
    end

    if (d_rdy) begin
      d_vld_nxt = c_vld_r && (c_grp_r == tsfc_pkg::GRP_Y2);
      if (c_vld_r) begin
        unique case (c_grp_r)
          tsfc_pkg::GRP_X1: fx_nxt = c_mean_r;
          tsfc_pkg::GRP_Y1: fy_nxt = c_mean_r;
          tsfc_pkg::GRP_X2: sx_nxt = c_mean_r;
          tsfc_pkg::GRP_Y2: begin
            d_pair_nxt.unstable = (dx > max_jitter) || (dy > max_jitter);
            d_pair_nxt.dx       = dx;
            d_pair_nxt.dy       = dy;
            d_pair_nxt.ax       = sum_x[tsfc_pkg::SMP_W:1];
            d_pair_nxt.ay       = sum_y[tsfc_pkg::SMP_W:1];
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
    end else begin
      c_vld_r <= c_vld_nxt;
      d_vld_r <= d_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_mean_r <= c_mean_nxt;
    c_grp_r  <= c_grp_nxt;
    fx_r     <= fx_nxt;
    fy_r     <= fy_nxt;
    sx_r     <= sx_nxt;
    d_pair_r <= d_pair_nxt;
  end

endmodule

### rtl/tsfc_calib.sv
// Window check, gain multiply, offset add and clamp, output register.
// Depends on tsfc_pkg. Drives the result channel of the top level.
module tsfc_calib (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                pair_vld,
  output logic                                pair_rdy,
  input  tsfc_pkg::pair_t                     pair,
  input  logic [tsfc_pkg::CFG_W-1:0]          raw_window,
  input  logic signed [tsfc_pkg::GAIN_W-1:0]  x_gain,
  input  logic signed [tsfc_pkg::GAIN_W-1:0]  y_gain,
  input  logic signed [tsfc_pkg::OFS_W-1:0]   x_offset,
  input  logic signed [tsfc_pkg::OFS_W-1:0]   y_offset,
  input  logic [tsfc_pkg::SCR_W-1:0]          screen_width,
  input  logic [tsfc_pkg::SCR_W-1:0]          screen_height,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          out_status,
  output logic [tsfc_pkg::SMP_W-1:0]          out_raw_x,
  output logic [tsfc_pkg::SMP_W-1:0]          out_raw_y,
  output logic [tsfc_pkg::SCR_W-1:0]          out_screen_x,
  output logic [tsfc_pkg::SCR_W-1:0]          out_screen_y
);

  localparam int SMP_W = tsfc_pkg::SMP_W;
  localparam int SCR_W = tsfc_pkg::SCR_W;
  localparam int P_W   = tsfc_pkg::CAL_PROD_W;
  localparam int V_W   = tsfc_pkg::CAL_V_W;
  localparam int HI_W  = V_W - tsfc_pkg::FRAC_W;

  logic                      e_vld_r, e_vld_nxt;
  tsfc_pkg::status_t         e_status_r, e_status_nxt;
  logic [SMP_W-1:0]          e_rawx_r, e_rawx_nxt;
  logic [SMP_W-1:0]          e_rawy_r, e_rawy_nxt;
  logic signed [P_W-1:0]     e_px_r, e_px_nxt;
  logic signed [P_W-1:0]     e_py_r, e_py_nxt;

  logic                      out_vld_r, out_vld_nxt;
  tsfc_pkg::status_t         out_status_r, out_status_nxt;
  logic [SMP_W-1:0]          out_rawx_r, out_rawx_nxt;
  logic [SMP_W-1:0]          out_rawy_r, out_rawy_nxt;
  logic [SCR_W-1:0]          out_scrx_r, out_scrx_nxt;
  logic [SCR_W-1:0]          out_scry_r, out_scry_nxt;

  logic                      e_rdy, f_rdy;
  logic [SMP_W-1:0]          xmin, xmax, ymin, ymax;
  logic                      outside;
  logic [SCR_W-1:0]          scr_x, scr_y;

  // v = prod + offset * 2^16; negative -> 0, above limit -> limit
  function automatic logic [SCR_W-1:0] clamp_scale(
    input logic signed [P_W-1:0]                    p,
    input logic signed [tsfc_pkg::OFS_W-1:0]        ofs,
    input logic [SCR_W-1:0]                         limit
  );
    logic signed [V_W-1:0] v;
    logic [HI_W-1:0]       hi;
    logic [SCR_W-1:0]      r;
    v  = V_W'(p) + (V_W'(ofs) <<< tsfc_pkg::FRAC_W);
    hi = v[V_W-1:tsfc_pkg::FRAC_W];
    if (v[V_W-1]) begin
      r = '0;
    end else if (hi > HI_W'(limit)) begin
      r = limit;
    end else begin
      r = hi[SCR_W-1:0];
    end
    return r;
  endfunction

  assign f_rdy    = !out_vld_r || !out_stall;
  assign e_rdy    = !e_vld_r || f_rdy;
  assign pair_rdy = e_rdy;

  assign xmin = raw_window[0*SMP_W +: SMP_W];
  assign xmax = raw_window[1*SMP_W +: SMP_W];
  assign ymin = raw_window[2*SMP_W +: SMP_W];
  assign ymax = raw_window[3*SMP_W +: SMP_W];

  assign outside = (pair.ax > xmax) || (pair.ax < xmin) ||
                   (pair.ay > ymax) || (pair.ay < ymin);

  assign scr_x = clamp_scale(e_px_r, x_offset, screen_width);
  assign scr_y = clamp_scale(e_py_r, y_offset, screen_height);

  always_comb begin
    e_vld_nxt      = e_vld_r;
    e_status_nxt   = e_status_r;
    e_rawx_nxt     = e_rawx_r;
    e_rawy_nxt     = e_rawy_r;
    e_px_nxt       = e_px_r;
    e_py_nxt       = e_py_r;
    out_vld_nxt    = out_vld_r;
    out_status_nxt = out_status_r;
    out_rawx_nxt   = out_rawx_r;
    out_rawy_nxt   = out_rawy_r;
    out_scrx_nxt   = out_scrx_r;
    out_scry_nxt   = out_scry_r;

    if (e_rdy) begin
      e_vld_nxt = pair_vld;
      if (pair_vld) begin
        priority if (pair.unstable) begin
          e_status_nxt = tsfc_pkg::STAT_UNSTABLE;
        end else if (outside) begin
          e_status_nxt = tsfc_pkg::STAT_RANGE;
        end else begin
          e_status_nxt = tsfc_pkg::STAT_OK;
        end
        e_rawx_nxt = pair.unstable ? pair.dx : pair.ax;
        e_rawy_nxt = pair.unstable ? pair.dy : pair.ay;
        e_px_nxt   = $signed({1'b0, pair.ax}) * x_gain;
        e_py_nxt   = $signed({1'b0, pair.ay}) * y_gain;
      end
    end

    if (f_rdy) begin
      out_vld_nxt = e_vld_r;
      if (e_vld_r) begin
        out_status_nxt = e_status_r;
        out_rawx_nxt   = e_rawx_r;
        out_rawy_nxt   = e_rawy_r;
        out_scrx_nxt   = (e_status_r == tsfc_pkg::STAT_OK) ? scr_x : '0;
        out_scry_nxt   = (e_status_r == tsfc_pkg::STAT_OK) ? scr_y : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      e_vld_r   <= e_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_status_r   <= e_status_nxt;
    e_rawx_r     <= e_rawx_nxt;
    e_rawy_r     <= e_rawy_nxt;
    e_px_r       <= e_px_nxt;
    e_py_r       <= e_py_nxt;
    out_status_r <= out_status_nxt;
    out_rawx_r   <= out_rawx_nxt;
    out_rawy_r   <= out_rawy_nxt;
    out_scrx_r   <= out_scrx_nxt;
    out_scry_r   <= out_scry_nxt;
  end

  assign out_valid    = out_vld_r;
  assign out_status   = out_status_r;
  assign out_raw_x    = out_rawx_r;
  assign out_raw_y    = out_rawy_r;
  assign out_screen_x = out_scrx_r;
  assign out_screen_y = out_scry_r;

endmodule

### rtl/touch_sample_filter_calibrate.sv
// Top level of the resistive touch sample filter and calibrator.
// Depends on tsfc_pkg, tsfc_accum, tsfc_mean and tsfc_calib.
//  - Input channel (in_valid / in_stall): one converter word per transaction;
//    the sample is in_raw_word[15:3]. Words arrive as N x, N y, N x, N y
//    with N = SAMPLES_PER_GROUP. in_start_req = 1 drops any partial
//    sequence and takes this word as the first of a new one.
//  - Result channel (out_valid / out_stall): one transaction per complete
//    sequence of 4*N words, carrying status, raw averages (or the jitter
//    when unstable) and the clamped screen coordinates.
//  - Config port: cfg_we writes cfg_wdata into register cfg_index at the
//    clock edge. Write only while the block is idle.
//  - Throughput: one word per cycle, sustained while the output is not stalled.
//  - Path: after the input register takes the last word of a sequence, the
//    result passes the accumulate, divide, pair check, gain multiply and
//    clamp/output registers in turn (stages B to F).
//  - Stall: each stage holds while its successor is full, so bubbles keep
//    taking words while a result waits; in_stall rises only once every
//    stage is occupied behind a stalled output.
//  - Reset (rst_n low, synchronous): pipeline empties, sequence position
//    and group accumulators clear, registers return to their defaults.
module touch_sample_filter_calibrate (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_start_req,
  input  logic [15:0]                          in_raw_word,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [1:0]                           out_status,
  output logic [tsfc_pkg::SMP_W-1:0]           out_raw_x,
  output logic [tsfc_pkg::SMP_W-1:0]           out_raw_y,
  output logic [tsfc_pkg::SCR_W-1:0]           out_screen_x,
  output logic [tsfc_pkg::SCR_W-1:0]           out_screen_y,
  input  logic                                 cfg_we,
  input  logic [tsfc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tsfc_pkg::CFG_W-1:0]           cfg_wdata
);

  localparam int SMP_W = tsfc_pkg::SMP_W;

  // configuration registers
  logic [SMP_W-1:0]                          max_jitter_r, max_jitter_nxt;
  logic [tsfc_pkg::CFG_W-1:0]                raw_window_r, raw_window_nxt;
  logic signed [tsfc_pkg::GAIN_W-1:0]        x_gain_r, x_gain_nxt;
  logic signed [tsfc_pkg::GAIN_W-1:0]        y_gain_r, y_gain_nxt;
  logic signed [tsfc_pkg::OFS_W-1:0]         x_offset_r, x_offset_nxt;
  logic signed [tsfc_pkg::OFS_W-1:0]         y_offset_r, y_offset_nxt;
  logic [tsfc_pkg::SCR_W-1:0]                scr_w_r, scr_w_nxt;
  logic [tsfc_pkg::SCR_W-1:0]                scr_h_r, scr_h_nxt;

  logic                                      trim_vld, trim_rdy;
  tsfc_pkg::trim_t                           trim;
  logic                                      pair_vld, pair_rdy;
  tsfc_pkg::pair_t                           pair;

  always_comb begin
    max_jitter_nxt = max_jitter_r;
    raw_window_nxt = raw_window_r;
    x_gain_nxt     = x_gain_r;
    y_gain_nxt     = y_gain_r;
    x_offset_nxt   = x_offset_r;
    y_offset_nxt   = y_offset_r;
    scr_w_nxt      = scr_w_r;
    scr_h_nxt      = scr_h_r;
    if (cfg_we) begin
      unique case (tsfc_pkg::cfg_idx_t'(cfg_index))
        tsfc_pkg::REG_MAX_JITTER:    max_jitter_nxt = cfg_wdata[SMP_W-1:0];
        tsfc_pkg::REG_RAW_WINDOW:    raw_window_nxt = cfg_wdata;
        tsfc_pkg::REG_X_GAIN:        x_gain_nxt     = cfg_wdata[tsfc_pkg::GAIN_W-1:0];
        tsfc_pkg::REG_Y_GAIN:        y_gain_nxt     = cfg_wdata[tsfc_pkg::GAIN_W-1:0];
        tsfc_pkg::REG_X_OFFSET:      x_offset_nxt   = cfg_wdata[tsfc_pkg::OFS_W-1:0];
        tsfc_pkg::REG_Y_OFFSET:      y_offset_nxt   = cfg_wdata[tsfc_pkg::OFS_W-1:0];
        tsfc_pkg::REG_SCREEN_WIDTH:  scr_w_nxt      = cfg_wdata[tsfc_pkg::SCR_W-1:0];
        tsfc_pkg::REG_SCREEN_HEIGHT: scr_h_nxt      = cfg_wdata[tsfc_pkg::SCR_W-1:0];
      endcase
    end
  end

  // defaults: jitter 50, full 13-bit window on both axes, unity gain, 240x320
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_jitter_r <= SMP_W'(50);
      raw_window_r <= {{SMP_W{1'b1}}, {SMP_W{1'b0}}, {SMP_W{1'b1}}, {SMP_W{1'b0}}};
      x_gain_r     <= tsfc_pkg::GAIN_W'(65536);
      y_gain_r     <= tsfc_pkg::GAIN_W'(65536);
      x_offset_r   <= '0;
      y_offset_r   <= '0;
      scr_w_r      <= tsfc_pkg::SCR_W'(240);
      scr_h_r      <= tsfc_pkg::SCR_W'(320);
    end else begin
      max_jitter_r <= max_jitter_nxt;
      raw_window_r <= raw_window_nxt;
      x_gain_r     <= x_gain_nxt;
      y_gain_r     <= y_gain_nxt;
      x_offset_r   <= x_offset_nxt;
      y_offset_r   <= y_offset_nxt;
      scr_w_r      <= scr_w_nxt;
      scr_h_r      <= scr_h_nxt;
    end
  end

  // stages A/B: input register, running sum/min/max, trimmed group sum
  tsfc_accum u_accum (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_start_req (in_start_req),
    .in_raw_word  (in_raw_word),
    .trim_vld     (trim_vld),
    .trim_rdy     (trim_rdy),
    .trim         (trim)
  );

  // stages C/D: reciprocal divide, mean storage, jitter check, averages
  tsfc_mean u_mean (
    .clk        (clk),
    .rst_n      (rst_n),
    .trim_vld   (trim_vld),
    .trim_rdy   (trim_rdy),
    .trim       (trim),
    .max_jitter (max_jitter_r),
    .pair_vld   (pair_vld),
    .pair_rdy   (pair_rdy),
    .pair       (pair)
  );

  // stages E/F: window check and gain multiply, then offset, clamp, output
  tsfc_calib u_calib (
    .clk           (clk),
    .rst_n         (rst_n),
    .pair_vld      (pair_vld),
    .pair_rdy      (pair_rdy),
    .pair          (pair),
    .raw_window    (raw_window_r),
    .x_gain        (x_gain_r),
    .y_gain        (y_gain_r),
    .x_offset      (x_offset_r),
    .y_offset      (y_offset_r),
    .screen_width  (scr_w_r),
    .screen_height (scr_h_r),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_raw_x     (out_raw_x),
    .out_raw_y     (out_raw_y),
    .out_screen_x  (out_screen_x),
    .out_screen_y  (out_screen_y)
  );

endmodule

### rtl/tsfc_checker.sv
// Port-level checker for touch_sample_filter_calibrate, bound to the top.
// Depends on tsfc_pkg and touch_sample_filter_calibrate_assert.svh.
`include "touch_sample_filter_calibrate_assert.svh"

module tsfc_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [1:0]                         out_status,
  input logic [tsfc_pkg::SMP_W-1:0]         out_raw_x,
  input logic [tsfc_pkg::SMP_W-1:0]         out_raw_y,
  input logic [tsfc_pkg::SCR_W-1:0]         out_screen_x,
  input logic [tsfc_pkg::SCR_W-1:0]         out_screen_y
);

  // a held result keeps valid and payload
  `TSFC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_status) && $stable(out_raw_x) && $stable(out_raw_y) && $stable(out_screen_x) && $stable(out_screen_y), "stalled result changed")

  // input backpressure only appears behind a blocked output
  `TSFC_ASSERT_NOW(a_stall_src, in_stall, out_valid && out_stall, "input stalled while output free")

  // screen coordinates are only reported on a good reading
  `TSFC_ASSERT_NOW(a_scr_zero, out_valid && (out_status != tsfc_pkg::STAT_OK), (out_screen_x == '0) && (out_screen_y == '0), "screen coords set on failed reading")

  // nothing comes out and the input is not stalled in the cycle right after reset
  `TSFC_ASSERT_NOW(a_rst_empty, $past(!rst_n), !out_valid && !in_stall, "pipeline not empty after reset")

endmodule

bind touch_sample_filter_calibrate tsfc_checker u_tsfc_checker (.*);
